// ===== rtl/core/pdbt_pkg.sv =====
// Shared types and constants for the PS/2 device byte transmitter.
package pdbt_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [15:0] DIVIDER_RESET = 16'd2000;

   // Frame phase boundaries: each bit of the frame spans two phases.
   localparam logic [4:0] PHASE_START_END  = 5'd1;
   localparam logic [4:0] PHASE_DATA_END   = 5'd17;
   localparam logic [4:0] PHASE_PARITY_END = 5'd19;
   localparam logic [4:0] PHASE_STOP_END   = 5'd21;
   localparam logic [4:0] PHASE_IDLE_END   = 5'd25;
   localparam logic [4:0] LAST_PHASE       = 5'd26;

   // Depth of the queues between the front, the engine and the result port.
   localparam int OP_QUEUE_DEPTH  = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       ps2_clock;
      logic       ps2_data;
      logic       push_dropped;
      logic [7:0] queue_count;
   } rsp_type;

   // Classified request as handed from the front to the engine.
   typedef struct packed {
      logic       is_tick;
      logic [7:0] data_byte;
   } op_type;

endpackage

// ===== rtl/core/pdbt_fifo.sv =====
// Small register-based first-in first-out queue.
module pdbt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The fill count never goes past the number of slots.
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_CNT)
      else $error("fifo count exceeds depth");

endmodule

// ===== rtl/core/pdbt_engine.sv =====
// Transmit engine: byte ring, half-bit timer, frame phase sequencer and line levels.
module pdbt_engine #(
   parameter int QUEUE_SLOTS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_avail,
   input  pdbt_pkg::op_type op,
   output logic             op_take,
   input  logic             rsp_room,
   output pdbt_pkg::rsp_type rsp,
   input  logic             csr_valid,
   input  logic [15:0]      csr_data
);

   localparam int PTR_W = $clog2(QUEUE_SLOTS);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);
   localparam logic [PTR_W:0]   SLOT_CNT  = (PTR_W + 1)'(QUEUE_SLOTS);

   logic [7:0]       ring_mem [QUEUE_SLOTS];
   logic [7:0]       cur_byte_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] fill_ff, fill_in;
   logic [15:0]      count_ff, count_in;
   logic [4:0]       phase_ff, phase_in;
   logic             clock_line_ff, clock_line_in;
   logic             data_line_ff, data_line_in;
   logic [15:0]      divider_ff;

   logic             is_push, is_tick, ring_full, wr_en, dropped, step;
   logic [PTR_W:0]   tail_sum, tail_wide;
   logic [PTR_W-1:0] wr_addr, head_next;
   logic [15:0]      count_inc;
   logic [3:0]       half_idx;
   logic [PTR_W+7:0] fill_wide;

   assign op_take   = op_avail && rsp_room;
   assign is_push   = op_take && !op.is_tick;
   assign is_tick   = op_take && op.is_tick;
   assign ring_full = (fill_ff == LAST_SLOT);
   assign wr_en     = is_push && !ring_full;
   assign dropped   = is_push && ring_full;

   assign tail_sum  = {1'b0, head_ff} + {1'b0, fill_ff};
   assign tail_wide = (tail_sum >= SLOT_CNT) ? tail_sum - SLOT_CNT : tail_sum;
   assign wr_addr   = tail_wide[PTR_W-1:0];
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;

   assign count_inc = count_ff + 16'd1;
   assign step      = is_tick && (fill_ff != '0) && (count_inc >= divider_ff);
   assign half_idx  = phase_ff[4:1] - 4'd1;

   always_comb begin
      head_in       = head_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      clock_line_in = clock_line_ff;
      data_line_in  = data_line_ff;
      if (wr_en) begin
         fill_in = fill_ff + 1'b1;
      end
      if (is_tick && fill_ff != '0) begin
         count_in = count_inc;
      end
      if (step) begin
         count_in      = '0;
         phase_in      = phase_ff + 5'd1;
         clock_line_in = phase_ff[0];
         if (phase_ff <= pdbt_pkg::PHASE_START_END) begin
            data_line_in = 1'b0;
         end else if (phase_ff <= pdbt_pkg::PHASE_DATA_END) begin
            data_line_in = cur_byte_ff[half_idx[2:0]];
         end else if (phase_ff <= pdbt_pkg::PHASE_PARITY_END) begin
            data_line_in = ~^cur_byte_ff;
         end else if (phase_ff <= pdbt_pkg::PHASE_STOP_END) begin
            data_line_in = 1'b1;
         end else if (phase_ff <= pdbt_pkg::PHASE_IDLE_END) begin
            clock_line_in = 1'b1;
            data_line_in  = 1'b1;
         end else begin
            // End of frame: retire the byte and start over.
            head_in       = head_next;
            fill_in       = fill_ff - 1'b1;
            clock_line_in = 1'b1;
            phase_in      = '0;
         end
      end
   end

   assign fill_wide = {8'd0, fill_in};

   always_comb begin
      rsp.ps2_clock    = clock_line_in;
      rsp.ps2_data     = data_line_in;
      rsp.push_dropped = dropped;
      rsp.queue_count  = fill_wide[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         fill_ff       <= '0;
         count_ff      <= '0;
         phase_ff      <= '0;
         clock_line_ff <= 1'b1;
         data_line_ff  <= 1'b1;
         divider_ff    <= pdbt_pkg::DIVIDER_RESET;
      end else begin
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         clock_line_ff <= clock_line_in;
         data_line_ff  <= data_line_in;
         if (csr_valid) begin
            divider_ff <= csr_data;
         end
      end
   end

   // The head byte is registered from the next head pointer; a write to the new head slot is forwarded.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= op.data_byte;
      end
      if (wr_en && wr_addr == head_in) begin
         cur_byte_ff <= op.data_byte;
      end else begin
         cur_byte_ff <= ring_mem[head_in];
      end
   end

   assert property (@(posedge clock) disable iff (reset) phase_ff <= pdbt_pkg::LAST_PHASE)
      else $error("frame phase out of range");

   // The ring only drains at end of frame, so an empty ring always sits at phase zero.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> phase_ff == '0 && count_ff == '0)
      else $error("timer or phase running with empty ring");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff >= 5'd1 && phase_ff <= pdbt_pkg::PHASE_STOP_END)
         |-> clock_line_ff == ~phase_ff[0])
      else $error("clock line out of step with frame phase");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == '0 |-> clock_line_ff == 1'b1)
      else $error("clock line low between frames");

endmodule

// ===== rtl/core/ps2_device_byte_transmitter.sv =====
// Top level of the PS/2 device byte transmitter.
// Requests enter on a queue-style port: req_item is taken at a rising edge
// with push high and full low. A request either queues one byte (command
// push) or advances time by one tick. Every request yields exactly one
// response with the clock and data line levels after it, a dropped flag for
// a push refused by a full byte ring, and the number of bytes waiting.
// Responses leave in order on rsp_item while empty is low; pop takes one.
// The half-bit divider is written through csr_valid/csr_data, which is
// always ready; write it only while no request is in flight.
// Throughput is one request per clock while responses are popped. The engine
// retires one request a cycle from the front queue into the response queue,
// from which its response leaves on rsp_item. When the response side is
// not popped, the engine stops and the front queue then raises full.
// Reset leaves the ring empty, both lines high, the divider at 2000 and
// both internal queues empty; the byte ring itself is not cleared.
module ps2_device_byte_transmitter #(
   parameter int QUEUE_SLOTS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pdbt_pkg::req_type  req_item,
   output logic               full,
   input  logic               pop,
   output pdbt_pkg::rsp_type  rsp_item,
   output logic               empty,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data
);

   localparam int OP_W  = $bits(pdbt_pkg::op_type);
   localparam int RSP_W = $bits(pdbt_pkg::rsp_type);

   pdbt_pkg::op_type  front_op, queued_op;
   pdbt_pkg::rsp_type engine_rsp;
   logic [OP_W-1:0]   queued_bits;
   logic [RSP_W-1:0]  rsp_bits;
   logic              op_empty, op_take, rsp_full;

   assign csr_ready = 1'b1;

   // Classify the request before it is queued for the engine.
   always_comb begin
      front_op.is_tick   = (req_item.command == pdbt_pkg::CMD_TICK);
      front_op.data_byte = req_item.data_byte;
   end

   pdbt_fifo #(
      .WIDTH (OP_W),
      .DEPTH (pdbt_pkg::OP_QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_op),
      .full      (full),
      .pop       (op_take),
      .pop_data  (queued_bits),
      .empty     (op_empty)
   );

   assign queued_op = pdbt_pkg::op_type'(queued_bits);

   pdbt_engine #(
      .QUEUE_SLOTS (QUEUE_SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .op_avail  (!op_empty),
      .op        (queued_op),
      .op_take   (op_take),
      .rsp_room  (!rsp_full),
      .rsp       (engine_rsp),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data)
   );

   pdbt_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (pdbt_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_take),
      .push_data (engine_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty)
   );

   assign rsp_item = pdbt_pkg::rsp_type'(rsp_bits);

endmodule

// ===== tb/ps2_device_byte_transmitter_tb.sv =====
// Self-checking testbench for the PS/2 device byte transmitter: request/response checking.
module ps2_device_byte_transmitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SLOTS = 256;
   localparam int RING_LIMIT = RING_SLOTS - 1;

   // Tracks the line levels and byte ring the block should have after each request.
   class ps2_line_scoreboard;
      logic [7:0]  ring [RING_SLOTS];
      logic [7:0]  head;
      int unsigned fill;
      logic [15:0] half_count;
      logic [15:0] divider;
      logic [4:0]  phase;
      logic        clk_line;
      logic        dat_line;
      pdbt_pkg::rsp_type expected_lines [$];
      int unsigned errors;

      function new();
         foreach (ring[i]) ring[i] = 8'h00;
         head       = '0;
         fill       = 0;
         half_count = '0;
         divider    = pdbt_pkg::DIVIDER_RESET;
         phase      = '0;
         clk_line   = 1'b1;
         dat_line   = 1'b1;
         errors     = 0;
      endfunction

      function void set_divider(logic [15:0] value);
         divider = value;
      endfunction

      function int waiting();
         return expected_lines.size();
      endfunction

      // One half-bit period has elapsed: drive the lines for the current phase.
      function void advance_phase();
         logic [7:0]  cur;
         int unsigned sel;
         cur = ring[head];
         clk_line = phase[0];
         if (phase > pdbt_pkg::PHASE_IDLE_END) begin
            // End of frame: the byte leaves the ring and the next frame starts.
            head       = head + 8'd1;
            if (fill > 0) fill--;
            clk_line   = 1'b1;
            half_count = '0;
            phase      = '0;
            return;
         end
         if (phase <= pdbt_pkg::PHASE_START_END) begin
            dat_line = 1'b0;
         end else if (phase <= pdbt_pkg::PHASE_DATA_END) begin
            sel = ((phase >> 1) - 1) & 7;
            dat_line = cur[sel];
         end else if (phase <= pdbt_pkg::PHASE_PARITY_END) begin
            dat_line = ~^cur;
         end else if (phase <= pdbt_pkg::PHASE_STOP_END) begin
            dat_line = 1'b1;
         end else begin
            clk_line = 1'b1;
            dat_line = 1'b1;
         end
         half_count = '0;
         phase      = phase + 5'd1;
      endfunction

      function void note_request(pdbt_pkg::req_type r);
         pdbt_pkg::rsp_type want;
         want.push_dropped = 1'b0;
         if (r.command == pdbt_pkg::CMD_PUSH) begin
            if (fill >= RING_LIMIT) begin
               want.push_dropped = 1'b1;
            end else begin
               ring[head + fill[7:0]] = r.data_byte;
               fill++;
            end
         end else if (fill > 0) begin
            half_count = half_count + 16'd1;
            if (half_count >= divider) advance_phase();
         end
         want.ps2_clock   = clk_line;
         want.ps2_data    = dat_line;
         want.queue_count = fill[7:0];
         expected_lines.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(pdbt_pkg::rsp_type got);
         pdbt_pkg::rsp_type want;
         if (expected_lines.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
            return;
         end
         want = expected_lines.pop_front();
         if (got.ps2_clock !== want.ps2_clock)
            report_mismatch($sformatf("ps2_clock %b, expected %b",
                                      got.ps2_clock, want.ps2_clock));
         if (got.ps2_data !== want.ps2_data)
            report_mismatch($sformatf("ps2_data %b, expected %b",
                                      got.ps2_data, want.ps2_data));
         if (got.push_dropped !== want.push_dropped)
            report_mismatch($sformatf("push_dropped %b, expected %b",
                                      got.push_dropped, want.push_dropped));
         if (got.queue_count !== want.queue_count)
            report_mismatch($sformatf("queue_count %0d, expected %0d",
                                      got.queue_count, want.queue_count));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              push;
   pdbt_pkg::req_type req_item;
   logic              full;
   logic              pop;
   pdbt_pkg::rsp_type rsp_item;
   logic              empty;
   logic              csr_valid;
   logic              csr_ready;
   logic [15:0]       csr_data;

   ps2_line_scoreboard sb;
   bit steady;
   bit hold_request;

   ps2_device_byte_transmitter dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_item  (req_item),
      .full      (full),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .empty     (empty),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Called at a falling edge; returns at a falling edge with push still high.
   task send_request(logic cmd, logic [7:0] value);
      pdbt_pkg::req_type r;
      r.command   = cmd;
      r.data_byte = value;
      while (!steady && $urandom_range(99) < 14) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (full);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task settle();
      push <= 1'b0;
      while (sb.waiting() != 0) @(negedge clock);
   endtask

   task write_divider(logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_divider(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
            pop <= 1'b0;
         end else begin
            pop <= !(!steady && $urandom_range(99) < 14);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) sb.check_response(rsp_item);
   end

   initial begin
      int   dividers [9];
      int   pct;
      logic cmd;
      dividers = '{1, 2, 1, 3, 0, 1, 2, 1, 5};
      sb = new();
      steady = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      push = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default divider: a tick on an empty ring holds, then the count only advances.
      send_request(pdbt_pkg::CMD_TICK, 8'h3C);
      send_request(pdbt_pkg::CMD_PUSH, 8'h00);
      send_request(pdbt_pkg::CMD_TICK, 8'hFF);
      send_request(pdbt_pkg::CMD_TICK, 8'h00);
      settle();

      // A zero divider steps the phase on every tick.
      write_divider(16'd0);
      send_request(pdbt_pkg::CMD_PUSH, 8'hFF);
      send_request(pdbt_pkg::CMD_PUSH, 8'h80);
      repeat (12) send_request(pdbt_pkg::CMD_TICK, 8'h00);
      settle();

      // Largest divider, then lowered below a count already reached.
      write_divider(16'hFFFF);
      send_request(pdbt_pkg::CMD_PUSH, 8'h5A);
      repeat (3) send_request(pdbt_pkg::CMD_TICK, 8'hA5);
      settle();
      write_divider(16'd1);
      repeat (2) send_request(pdbt_pkg::CMD_TICK, 8'h00);

      foreach (dividers[p]) begin
         settle();
         write_divider(dividers[p][15:0]);
         steady = (p == 4);
         if (p == 2) hold_request = 1'b1;
         pct = $urandom_range(20, 5);
         repeat (110) begin
            cmd = ($urandom_range(99) < pct) ? pdbt_pkg::CMD_PUSH : pdbt_pkg::CMD_TICK;
            send_request(cmd, 8'($urandom));
         end
      end
      steady = 1'b0;

      // Fill the ring past capacity so that pushes are refused.
      settle();
      write_divider(16'hFFFF);
      repeat (270) send_request(pdbt_pkg::CMD_PUSH, 8'($urandom));
      repeat (5) send_request(pdbt_pkg::CMD_TICK, 8'($urandom));
      settle();
      write_divider(16'd1);
      repeat (200) begin
         cmd = ($urandom_range(99) < 3) ? pdbt_pkg::CMD_PUSH : pdbt_pkg::CMD_TICK;
         send_request(cmd, 8'($urandom));
      end

      settle();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.waiting() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pdbt_pkg.sv
rtl/core/pdbt_fifo.sv
rtl/core/pdbt_engine.sv
rtl/core/ps2_device_byte_transmitter.sv
tb/ps2_device_byte_transmitter_tb.sv
